@@ design/urk4_pkg.sv @@
// urk4_pkg: shared constants, types and helper functions for the unicycle rk4 step
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package urk4_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_ENTRIES = 30;
    localparam int CORDIC_STAGES =
        (CORDIC_ITERATIONS < ATAN_ENTRIES) ? CORDIC_ITERATIONS : ATAN_ENTRIES;

    localparam int RED_STEPS = 17;
    localparam int OFFSET_SHIFT = RED_STEPS - 2;
    localparam int SC_LATENCY = RED_STEPS + CORDIC_STAGES + 3;
    localparam int FRONT_LATENCY = 2;
    localparam int BACK_LATENCY = 5;
    localparam int TOTAL_LATENCY = FRONT_LATENCY + SC_LATENCY + BACK_LATENCY;

    localparam int ANG_W = 34;
    localparam int RED_W = 51;
    localparam int CQ_W = 34;
    localparam int Z_W = 35;
    localparam int TRIG_W = CQ_W - 14;
    localparam int SUM_W = 42;

    localparam logic [RED_W-1:0] TWO_PI_R = RED_W'(36'd26986075409);
    localparam logic [RED_W-1:0] RED_OFFSET = TWO_PI_R << OFFSET_SHIFT;
    localparam logic signed [35:0] TWO_PI_Q32 = 36'sd26986075409;
    localparam logic [RED_W-1:0] PI_Q32 = RED_W'(36'd13493037705);
    localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CQ_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [SUM_W-1:0] SAT_MAX = 42'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -42'sd2147483648;

    localparam logic [15:0] DEFAULT_STEP_RESET = 16'd6554;

    typedef struct packed {
        logic signed [31:0]      px;
        logic signed [31:0]      py;
        logic signed [ANG_W-1:0] th_f;
        logic signed [ANG_W-1:0] v;
        logic signed [ANG_W-1:0] v_h;
        logic signed [ANG_W-1:0] v_f;
        logic [15:0]             dt;
    } side_t;

    typedef struct packed {
        logic                    valid;
        side_t                   side;
        logic signed [ANG_W-1:0] ang_k1;
        logic signed [ANG_W-1:0] ang_k2;
        logic signed [ANG_W-1:0] ang_k4;
    } front_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } trig_t;

    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic signed [Z_W-1:0] a;
        unique case (i)
            0:  a = 35'sd843314857;
            1:  a = 35'sd497837829;
            2:  a = 35'sd263043837;
            3:  a = 35'sd133525159;
            4:  a = 35'sd67021687;
            5:  a = 35'sd33543516;
            6:  a = 35'sd16775851;
            7:  a = 35'sd8388437;
            8:  a = 35'sd4194283;
            9:  a = 35'sd2097149;
            10: a = 35'sd1048576;
            11: a = 35'sd524288;
            12: a = 35'sd262144;
            13: a = 35'sd131072;
            14: a = 35'sd65536;
            15: a = 35'sd32768;
            16: a = 35'sd16384;
            17: a = 35'sd8192;
            18: a = 35'sd4096;
            19: a = 35'sd2048;
            20: a = 35'sd1024;
            21: a = 35'sd512;
            22: a = 35'sd256;
            23: a = 35'sd128;
            24: a = 35'sd64;
            25: a = 35'sd32;
            26: a = 35'sd16;
            27: a = 35'sd8;
            28: a = 35'sd4;
            29: a = 35'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/urk4_front.sv @@
// urk4_front: step selection, rate products and the half and full step states
// depends on urk4_pkg
`timescale 1ns / 1ps
`default_nettype none

module urk4_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] heading,
    input  wire logic signed [31:0] speed,
    input  wire logic signed [31:0] accel,
    input  wire logic signed [31:0] yaw_rate,
    input  wire logic signed [16:0] step_time,
    input  wire logic [15:0]        default_step,
    output urk4_pkg::front_t        front
);

    logic               valid_a_reg;
    logic               valid_b_reg;
    logic signed [48:0] pw_reg;
    logic signed [48:0] pa_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [31:0] th_reg;
    logic signed [31:0] v_reg;
    logic [15:0]        dt_reg;
    logic [15:0]        dt_next;
    urk4_pkg::front_t   front_reg;
    urk4_pkg::front_t   front_next;

    assign dt_next = step_time[16] ? default_step : step_time[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pw_reg <= $signed({1'b0, dt_next}) * yaw_rate;
        pa_reg <= $signed({1'b0, dt_next}) * accel;
        px_reg <= pos_x;
        py_reg <= pos_y;
        th_reg <= heading;
        v_reg <= speed;
        dt_reg <= dt_next;
        front_reg <= front_next;
    end

    always_comb
    begin
        front_next.valid = valid_a_reg;
        front_next.side.px = px_reg;
        front_next.side.py = py_reg;
        front_next.side.dt = dt_reg;
        front_next.side.v = urk4_pkg::ANG_W'(v_reg);
        front_next.side.v_h = urk4_pkg::ANG_W'(v_reg)
                            + urk4_pkg::ANG_W'($signed(pa_reg[48:17]));
        front_next.side.v_f = urk4_pkg::ANG_W'(v_reg)
                            + urk4_pkg::ANG_W'($signed(pa_reg[48:16]));
        front_next.side.th_f = urk4_pkg::ANG_W'(th_reg)
                             + urk4_pkg::ANG_W'($signed(pw_reg[48:16]));
        front_next.ang_k1 = urk4_pkg::ANG_W'(th_reg);
        front_next.ang_k2 = urk4_pkg::ANG_W'(th_reg)
                          + urk4_pkg::ANG_W'($signed(pw_reg[48:17]));
        front_next.ang_k4 = front_next.side.th_f;
    end

    always_comb
    begin
        front = front_reg;
        front.valid = valid_b_reg;
    end

endmodule

`default_nettype wire

@@ design/urk4_sincos.sv @@
// urk4_sincos: pipelined angle reduction and rotation-mode cordic, one step per stage
// depends on urk4_pkg
`timescale 1ns / 1ps
`default_nettype none

module urk4_sincos (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic signed [urk4_pkg::ANG_W-1:0] angle,
    output logic                                  out_valid,
    output urk4_pkg::trig_t                       trig
);

    localparam int RS = urk4_pkg::RED_STEPS;
    localparam int CS = urk4_pkg::CORDIC_STAGES;

    logic [urk4_pkg::RED_W-1:0]        red_reg [RS+1];
    logic                              red_v_reg [RS+1];
    logic signed [urk4_pkg::RED_W-1:0] ang_ext;
    logic [urk4_pkg::RED_W-1:0]        red_next;

    logic signed [urk4_pkg::CQ_W-1:0] cx_reg [CS+1];
    logic signed [urk4_pkg::CQ_W-1:0] cy_reg [CS+1];
    logic signed [urk4_pkg::Z_W-1:0]  cz_reg [CS+1];
    logic                             cneg_reg [CS+1];
    logic                             cv_reg [CS+1];

    logic signed [35:0]               rs_next;
    logic signed [urk4_pkg::Z_W-1:0]  z_next;
    logic                             neg_next;

    urk4_pkg::trig_t                  trig_reg;
    urk4_pkg::trig_t                  trig_next;
    logic                             out_v_reg;
    logic signed [urk4_pkg::CQ_W-1:0] xf;
    logic signed [urk4_pkg::CQ_W-1:0] yf;

    // shift into q32 and lift by a multiple of 2pi so the value is nonnegative
    assign ang_ext = urk4_pkg::RED_W'(angle);
    assign red_next = $unsigned(ang_ext <<< 16) + urk4_pkg::RED_OFFSET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_v_reg[0] <= 1'b0;
        end
        else
        begin
            red_v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg[0] <= red_next;
    end

    for (genvar j = 0; j < RS; j++)
    begin : g_red
        localparam logic [urk4_pkg::RED_W-1:0] M = urk4_pkg::TWO_PI_R << (RS - 1 - j);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                red_v_reg[j+1] <= 1'b0;
            end
            else
            begin
                red_v_reg[j+1] <= red_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            red_reg[j+1] <= (red_reg[j] >= M) ? (red_reg[j] - M) : red_reg[j];
        end
    end

    // fold into (-pi, pi], then into the right half plane
    always_comb
    begin
        if (red_reg[RS] > urk4_pkg::PI_Q32)
        begin
            rs_next = $signed({1'b0, red_reg[RS][34:0]}) - urk4_pkg::TWO_PI_Q32;
        end
        else
        begin
            rs_next = $signed({1'b0, red_reg[RS][34:0]});
        end
        z_next = urk4_pkg::Z_W'($signed(rs_next[35:2]));
        neg_next = 1'b0;
        if (z_next > urk4_pkg::HALF_PI_Q30)
        begin
            z_next = z_next - urk4_pkg::PI_Q30;
            neg_next = 1'b1;
        end
        else if (z_next < -urk4_pkg::HALF_PI_Q30)
        begin
            z_next = z_next + urk4_pkg::PI_Q30;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else
        begin
            cv_reg[0] <= red_v_reg[RS];
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg[0] <= urk4_pkg::CORDIC_GAIN_Q30;
        cy_reg[0] <= '0;
        cz_reg[0] <= z_next;
        cneg_reg[0] <= neg_next;
    end

    for (genvar i = 0; i < CS; i++)
    begin : g_cordic
        localparam logic signed [urk4_pkg::Z_W-1:0] ATAN = urk4_pkg::atan_q30(i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            cneg_reg[i+1] <= cneg_reg[i];
            if (!cz_reg[i][urk4_pkg::Z_W-1])
            begin
                cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] - ATAN;
            end
            else
            begin
                cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] + ATAN;
            end
        end
    end

    assign xf = cneg_reg[CS] ? -cx_reg[CS] : cx_reg[CS];
    assign yf = cneg_reg[CS] ? -cy_reg[CS] : cy_reg[CS];

    always_comb
    begin
        trig_next.c = xf[urk4_pkg::CQ_W-1:14];
        trig_next.s = yf[urk4_pkg::CQ_W-1:14];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= cv_reg[CS];
        end
    end

    always_ff @(posedge clk)
    begin
        trig_reg <= trig_next;
    end

    assign out_valid = out_v_reg;
    assign trig = trig_reg;

endmodule

`default_nettype wire

@@ design/urk4_combine.sv @@
// urk4_combine: derivative products, rk4 weighting, scaling by dt/6 and saturation
// depends on urk4_pkg
`timescale 1ns / 1ps
`default_nettype none

module urk4_combine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire urk4_pkg::side_t    side,
    input  wire urk4_pkg::trig_t    trig_k1,
    input  wire urk4_pkg::trig_t    trig_k2,
    input  wire urk4_pkg::trig_t    trig_k4,
    output logic                    out_valid,
    output logic signed [31:0]      next_x,
    output logic signed [31:0]      next_y,
    output logic signed [31:0]      next_heading,
    output logic signed [31:0]      next_speed
);

    localparam int P_W = urk4_pkg::ANG_W + urk4_pkg::TRIG_W;
    localparam int D_W = P_W - 16;
    localparam int SX_W = 40;
    localparam int M_W = SX_W + 17;
    localparam int HI_W = SX_W - 18;
    localparam int N_W = 24;

    logic [4:0]            v_reg;
    urk4_pkg::side_t       side1_reg;
    urk4_pkg::side_t       side2_reg;
    urk4_pkg::side_t       side3_reg;
    urk4_pkg::side_t       side4_reg;

    logic signed [P_W-1:0] px1_reg;
    logic signed [P_W-1:0] py1_reg;
    logic signed [P_W-1:0] px2_reg;
    logic signed [P_W-1:0] py2_reg;
    logic signed [P_W-1:0] px4_reg;
    logic signed [P_W-1:0] py4_reg;

    logic signed [SX_W-1:0] sx_reg;
    logic signed [SX_W-1:0] sy_reg;
    logic signed [M_W-1:0]  mx_reg;
    logic signed [M_W-1:0]  my_reg;

    logic signed [SX_W-1:0] yx;
    logic signed [SX_W-1:0] yy;
    logic signed [HI_W-1:0] hix;
    logic signed [HI_W-1:0] hiy;
    logic [N_W-1:0]         nx;
    logic [N_W-1:0]         ny;
    logic signed [SX_W-1:0] hmx_reg;
    logic signed [SX_W-1:0] hmy_reg;
    logic [2*N_W-1:0]       qmx_reg;
    logic [2*N_W-1:0]       qmy_reg;

    logic signed [urk4_pkg::SUM_W-1:0] incx;
    logic signed [urk4_pkg::SUM_W-1:0] incy;
    logic signed [31:0] nx_reg;
    logic signed [31:0] ny_reg;
    logic signed [31:0] nh_reg;
    logic signed [31:0] ns_reg;

    localparam logic [N_W-1:0] N_OFFSET = N_W'(3) << 21;
    localparam logic [N_W-1:0] RECIP3 = 24'd5592406;
    localparam logic signed [N_W:0] Q_OFFSET = 25'sd2097152;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // split so that floor(y/3) = hi * 87381 + floor((hi + lo) / 3)
    assign yx = mx_reg[M_W-1:17];
    assign yy = my_reg[M_W-1:17];
    assign hix = yx[SX_W-1:18];
    assign hiy = yy[SX_W-1:18];
    assign nx = N_W'(hix) + N_W'(yx[17:0]) + N_OFFSET;
    assign ny = N_W'(hiy) + N_W'(yy[17:0]) + N_OFFSET;

    assign incx = urk4_pkg::SUM_W'(hmx_reg)
                + urk4_pkg::SUM_W'($signed({1'b0, qmx_reg[2*N_W-1:N_W]}) - Q_OFFSET);
    assign incy = urk4_pkg::SUM_W'(hmy_reg)
                + urk4_pkg::SUM_W'($signed({1'b0, qmy_reg[2*N_W-1:N_W]}) - Q_OFFSET);

    always_ff @(posedge clk)
    begin
        side1_reg <= side;
        px1_reg <= side.v * trig_k1.c;
        py1_reg <= side.v * trig_k1.s;
        px2_reg <= side.v_h * trig_k2.c;
        py2_reg <= side.v_h * trig_k2.s;
        px4_reg <= side.v_f * trig_k4.c;
        py4_reg <= side.v_f * trig_k4.s;

        side2_reg <= side1_reg;
        sx_reg <= SX_W'($signed(px1_reg[P_W-1:16]))
                + (SX_W'($signed(px2_reg[P_W-1:16])) <<< 2)
                + SX_W'($signed(px4_reg[P_W-1:16]));
        sy_reg <= SX_W'($signed(py1_reg[P_W-1:16]))
                + (SX_W'($signed(py2_reg[P_W-1:16])) <<< 2)
                + SX_W'($signed(py4_reg[P_W-1:16]));

        side3_reg <= side2_reg;
        mx_reg <= $signed({1'b0, side2_reg.dt}) * sx_reg;
        my_reg <= $signed({1'b0, side2_reg.dt}) * sy_reg;

        side4_reg <= side3_reg;
        hmx_reg <= hix * 18'sd87381;
        hmy_reg <= hiy * 18'sd87381;
        qmx_reg <= nx * RECIP3;
        qmy_reg <= ny * RECIP3;

        nx_reg <= urk4_pkg::sat32(urk4_pkg::SUM_W'(side4_reg.px) + incx);
        ny_reg <= urk4_pkg::sat32(urk4_pkg::SUM_W'(side4_reg.py) + incy);
        nh_reg <= urk4_pkg::sat32(urk4_pkg::SUM_W'(side4_reg.th_f));
        ns_reg <= urk4_pkg::sat32(urk4_pkg::SUM_W'(side4_reg.v_f));
    end

    assign out_valid = v_reg[4];
    assign next_x = nx_reg;
    assign next_y = ny_reg;
    assign next_heading = nh_reg;
    assign next_speed = ns_reg;

endmodule

`default_nettype wire

@@ design/unicycle_rk4_step.sv @@
// unicycle_rk4_step: top level of the rk4 unicycle state propagator
// depends on urk4_pkg, urk4_front, urk4_sincos and urk4_combine
`timescale 1ns / 1ps
`default_nettype none

// One item enters on every clock cycle at which start is high; busy is always low.
// Each result appears with done after passing these stages (with 16 cordic iterations:
// 2 front stages, 1 angle offset stage, 17 angle reduction steps, 1 fold stage,
// one stage per cordic iteration, 1 output stage and 5 combine stages), in order.
// The latency follows from the angle reduction and cordic pipelines, one step per
// stage; the receiver cannot stall, so done must be taken when it is shown.

module unicycle_rk4_step (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] heading,
    input  wire logic signed [31:0] speed,
    input  wire logic signed [31:0] accel,
    input  wire logic signed [31:0] yaw_rate,
    input  wire logic signed [16:0] step_time,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,
    output logic                    done,
    output logic signed [31:0]      next_x,
    output logic signed [31:0]      next_y,
    output logic signed [31:0]      next_heading,
    output logic signed [31:0]      next_speed
);

    localparam int SL = urk4_pkg::SC_LATENCY;

    logic [15:0]      default_step_reg;
    logic [15:0]      default_step_next;
    urk4_pkg::front_t front;
    urk4_pkg::side_t  delay_reg [SL];
    urk4_pkg::trig_t  trig_k1;
    urk4_pkg::trig_t  trig_k2;
    urk4_pkg::trig_t  trig_k4;
    logic             sc_valid_k1;
    logic             sc_valid_k2;
    logic             sc_valid_k4;

    assign busy = 1'b0;
    assign default_step_next = cfg_wr_en ? cfg_wr_data : default_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_step_reg <= urk4_pkg::DEFAULT_STEP_RESET;
        end
        else
        begin
            default_step_reg <= default_step_next;
        end
    end

    urk4_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start && !busy),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .heading      (heading),
        .speed        (speed),
        .accel        (accel),
        .yaw_rate     (yaw_rate),
        .step_time    (step_time),
        .default_step (default_step_reg),
        .front        (front)
    );

    urk4_sincos u_sc_k1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front.valid),
        .angle     (front.ang_k1),
        .out_valid (sc_valid_k1),
        .trig      (trig_k1)
    );

    urk4_sincos u_sc_k2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front.valid),
        .angle     (front.ang_k2),
        .out_valid (sc_valid_k2),
        .trig      (trig_k2)
    );

    urk4_sincos u_sc_k4 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front.valid),
        .angle     (front.ang_k4),
        .out_valid (sc_valid_k4),
        .trig      (trig_k4)
    );

    // side data waits alongside the trig pipelines
    always_ff @(posedge clk)
    begin
        delay_reg[0] <= front.side;
        for (int i = 1; i < SL; i++)
        begin
            delay_reg[i] <= delay_reg[i-1];
        end
    end

    urk4_combine u_combine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sc_valid_k1 && sc_valid_k2 && sc_valid_k4),
        .side         (delay_reg[SL-1]),
        .trig_k1      (trig_k1),
        .trig_k2      (trig_k2),
        .trig_k4      (trig_k4),
        .out_valid    (done),
        .next_x       (next_x),
        .next_y       (next_y),
        .next_heading (next_heading),
        .next_speed   (next_speed)
    );

endmodule

`default_nettype wire

@@ design/urk4_checker.sv @@
// urk4_checker: port-level assertions for unicycle_rk4_step, bound to the top level
// depends on urk4_pkg and unicycle_rk4_step
`timescale 1ns / 1ps
`default_nettype none

module urk4_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic signed [31:0] pos_x,
    input wire logic signed [31:0] heading,
    input wire logic signed [16:0] step_time,
    input wire logic               done,
    input wire logic signed [31:0] next_x,
    input wire logic signed [31:0] next_heading
);

    localparam int LAT = urk4_pkg::TOTAL_LATENCY;

    // every transfer in gives one result at the end of the whole pipeline
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("transfer without result");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LAT !done)
        else $error("result without transfer");

    // a zero step passes x and heading unchanged
    a_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && step_time == 17'sd0) |->
        ##LAT (next_x == $past(pos_x, LAT) && next_heading == $past(heading, LAT)))
        else $error("zero step changed the state");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

endmodule

bind unicycle_rk4_step urk4_checker u_urk4_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .pos_x        (pos_x),
    .heading      (heading),
    .step_time    (step_time),
    .done         (done),
    .next_x       (next_x),
    .next_heading (next_heading)
);

`default_nettype wire
